>>> rtl/rc_servo_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// rc servo frame decoder assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RC_SERVO_FRAME_DECODER_DEFINES_SVH
`define RC_SERVO_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define RCSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rcsd_pkg.sv
// ----------------------------------------------------------------------------
// rcsd_pkg
// constants, codes and types shared by the rc servo frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rcsd_pkg;

  localparam int CHANNELS  = 14;
  localparam int FRAME_LEN = 2 * CHANNELS + 4;
  localparam int CH_W      = 4;
  localparam int POS_W     = 6;
  localparam int ADDR_W    = CH_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam logic [15:0] SUM_INIT     = 16'hFFFF;
  localparam logic [15:0] CENTER_VALUE = 16'd1500;
  localparam logic [7:0]  CMD_RESET    = 8'd64;

  localparam logic REQ_FRAME   = 1'b0;
  localparam logic REQ_READ    = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic            shadow_we;
    logic [CH_W-1:0] shadow_ch;
    logic [15:0]     shadow_word;
    logic            done;
    logic            pass;
  } frame_evt_t;

endpackage

`default_nettype wire

>>> rtl/rcsd_frame_check.sv
// ----------------------------------------------------------------------------
// rcsd_frame_check
// byte position, running checksum, header check and channel word assembly
// ----------------------------------------------------------------------------
`default_nettype none

module rcsd_frame_check (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [7:0]        servo_command,
  output rcsd_pkg::frame_evt_t   evt
);

  localparam logic [rcsd_pkg::POS_W-1:0] LEN_POS =
    rcsd_pkg::POS_W'(rcsd_pkg::FRAME_LEN);
  localparam logic [rcsd_pkg::POS_W-1:0] CHK_LO_POS =
    rcsd_pkg::POS_W'(rcsd_pkg::FRAME_LEN - 2);
  localparam logic [rcsd_pkg::POS_W-1:0] ONE = rcsd_pkg::POS_W'(1);
  localparam logic [rcsd_pkg::POS_W-1:0] TWO = rcsd_pkg::POS_W'(2);

  logic [rcsd_pkg::POS_W-1:0] pos_r, pos_nxt, pos_a, pos_m2;
  logic [15:0]                sum_r, sum_nxt, sum_a;
  logic [15:0]                chk_r, chk_nxt, chk_a;
  logic                       hdr_r, hdr_nxt, hdr_a;
  logic [7:0]                 lowb_r, lowb_nxt;
  logic                       live;

  always_comb begin
    live   = pos_r < LEN_POS;
    pos_m2 = pos_r - TWO;
    pos_a  = pos_r;
    sum_a  = sum_r;
    chk_a  = chk_r;
    hdr_a  = hdr_r;
    lowb_nxt = lowb_r;
    evt = '0;
    if (live) begin
      pos_a = pos_r + ONE;
      if (pos_r == '0 && data_byte != 8'(rcsd_pkg::FRAME_LEN)) begin
        hdr_a = 1'b0;
      end
      if (pos_r == ONE && data_byte != servo_command) begin
        hdr_a = 1'b0;
      end
      if (pos_r < CHK_LO_POS) begin
        sum_a = sum_r - {8'd0, data_byte};
        if (pos_r >= TWO) begin
          if (!pos_r[0]) begin
            lowb_nxt = data_byte;
          end else begin
            evt.shadow_we   = byte_en;
            evt.shadow_ch   = pos_m2[rcsd_pkg::CH_W:1];
            evt.shadow_word = {data_byte, lowb_r};
          end
        end
      end else if (pos_r == CHK_LO_POS) begin
        chk_a = {chk_r[15:8], data_byte};
      end else begin
        chk_a = {data_byte, chk_r[7:0]};
      end
    end
    evt.done = byte_en && last_byte;
    evt.pass = (pos_a >= LEN_POS) && hdr_a && (sum_a == chk_a);
    if (last_byte) begin
      pos_nxt = '0;
      sum_nxt = rcsd_pkg::SUM_INIT;
      chk_nxt = '0;
      hdr_nxt = 1'b1;
    end else begin
      pos_nxt = pos_a;
      sum_nxt = sum_a;
      chk_nxt = chk_a;
      hdr_nxt = hdr_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= rcsd_pkg::SUM_INIT;
      chk_r <= '0;
      hdr_r <= 1'b1;
    end else if (byte_en) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      chk_r <= chk_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      lowb_r <= lowb_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rc_servo_frame_decoder.sv
// ----------------------------------------------------------------------------
// rc_servo_frame_decoder
// serial decoder for a 32-byte rc receiver servo frame with channel readback
//
// in_ beats carry either one frame byte (tuser = 0, tlast on the buffer's
// final byte) or a channel read request (tuser = 1). a frame byte without
// tlast produces no out_ beat; a final byte produces one status beat and a
// read request produces one channel beat. one beat is accepted per cycle
// unless out_ stalls, and its result reaches the output register the next cycle.
// channel words go into the spare bank of a two-bank channel ram; a frame
// that passes swaps the banks, so a commit needs no copy and a read
// right behind it sees the new words. the ram has one write and one
// registered read port.
// reset clears the frame state and the error count, sets servo_command to
// 64 and makes every channel read 1500 until the first good frame.
// when out_tready is low the result holds and in_tready drops until it is
// taken. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc_servo_frame_decoder_defines.svh"

module rc_servo_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // data_byte[7:0], channel_index[11:8]
  input  wire logic        in_tlast,
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // frame_ok[0], error_count[32:1],
                                       // channel_value[48:33]
  output logic             out_tuser,  // result_kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  rcsd_pkg::frame_evt_t evt;

  logic                       acc, is_read, byte_en, emit;
  logic [rcsd_pkg::CH_W-1:0]  idx;
  logic [7:0]                 cmd_r;
  logic                       bank_r, committed_r;
  logic [31:0]                reject_count_r, reject_count_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       kind_r, ok_r, oor_r, dflt_r;
  logic [31:0]                count_r;
  logic [15:0]                rdata_r, chan_val;
  logic [15:0]                mem [0:rcsd_pkg::MEM_DEPTH-1];

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_read   = (in_tuser == rcsd_pkg::REQ_READ);
  assign byte_en   = acc && !is_read;
  assign idx       = in_tdata[11:8];
  assign emit      = (acc && is_read) || evt.done;

  rcsd_frame_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_en       (byte_en),
    .data_byte     (in_tdata[7:0]),
    .last_byte     (in_tlast),
    .servo_command (cmd_r),
    .evt           (evt)
  );

  // channel ram: the spare bank takes shadow words, the live bank serves reads
  always_ff @(posedge clk) begin
    if (evt.shadow_we) begin
      mem[{~bank_r, evt.shadow_ch}] <= evt.shadow_word;
    end
    if (acc && is_read) begin
      rdata_r <= mem[{bank_r, idx}];
    end
  end

  always_comb begin
    reject_count_nxt = reject_count_r;
    if (evt.done && !evt.pass) begin
      reject_count_nxt = reject_count_r + 32'd1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r          <= rcsd_pkg::CMD_RESET;
      bank_r         <= 1'b0;
      committed_r    <= 1'b0;
      reject_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cmd_r <= cfg_data;
      end
      if (evt.done && evt.pass) begin
        bank_r      <= ~bank_r;
        committed_r <= 1'b1;
      end
      reject_count_r <= reject_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= is_read ? rcsd_pkg::KIND_READ : rcsd_pkg::KIND_STATUS;
      ok_r    <= !is_read && evt.pass;
      count_r <= reject_count_nxt;
      oor_r   <= {1'b0, idx} >= (rcsd_pkg::CH_W + 1)'(rcsd_pkg::CHANNELS);
      dflt_r  <= !committed_r;
    end
  end

  always_comb begin
    chan_val = '0;
    if (kind_r == rcsd_pkg::KIND_READ && !oor_r) begin
      chan_val = dflt_r ? rcsd_pkg::CENTER_VALUE : rdata_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {7'd0, chan_val, count_r, ok_r};

  `RCSD_ASSERT_NEXT(a_bank_swap, evt.done && evt.pass, bank_r != $past(bank_r),
    "bank did not swap after a good frame")
  `RCSD_ASSERT_NEXT(a_reject_inc, evt.done && !evt.pass,
    reject_count_r == $past(reject_count_r) + 32'd1, "reject count did not advance")
  `RCSD_ASSERT_SAME(a_status_zero, out_tvalid && out_tuser == rcsd_pkg::KIND_STATUS,
    out_tdata[48:33] == 16'd0, "status beat carries a channel value")
  `RCSD_ASSERT_SAME(a_commit_src, $rose(committed_r), $past(evt.done && evt.pass),
    "channels committed without a good frame")
  `RCSD_ASSERT_NEXT(a_read_result, acc && is_read,
    out_tvalid && out_tuser == rcsd_pkg::KIND_READ, "read request gave no read beat")

endmodule

`default_nettype wire

>>> sim/frame_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_decode_checker
// watches the in_, out_ and cfg_ channels of the rc servo frame decoder,
// keeps its own copy of the frame state, channel store and error count,
// predicts the result of each accepted read request and last frame byte and
// compares each accepted out_ beat field by field with the oldest prediction
// ----------------------------------------------------------------------------
module frame_decode_checker
  import rcsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tlast,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic        kind;
    logic        ok;
    logic [31:0] errs;
    logic [15:0] value;
  } decoded_result_t;

  decoded_result_t due_results[$];

  logic [7:0]  servo_cmd;
  logic [5:0]  frame_pos;
  logic [15:0] sum_left;
  logic        header_ok;
  logic [15:0] sent_check;
  logic [15:0] pending_words[CHANNELS];
  logic [15:0] servo_words[CHANNELS];
  logic [31:0] rejects;

  task automatic clear_frame();
    frame_pos  = '0;
    sum_left   = SUM_INIT;
    header_ok  = 1'b1;
    sent_check = '0;
  endtask

  task automatic absorb_frame_byte(input logic [7:0] b);
    int ch;
    if (frame_pos < FRAME_LEN) begin
      if (frame_pos == 0 && b != 8'(FRAME_LEN))
        header_ok = 1'b0;
      if (frame_pos == 1 && b != servo_cmd)
        header_ok = 1'b0;
      if (frame_pos < FRAME_LEN - 2) begin
        sum_left = sum_left - 16'(b);
        if (frame_pos >= 2) begin
          ch = (int'(frame_pos) - 2) >> 1;
          if (frame_pos[0] == 1'b0)
            pending_words[ch][7:0] = b;
          else
            pending_words[ch][15:8] = b;
        end
      end else if (frame_pos == FRAME_LEN - 2) begin
        sent_check[7:0] = b;
      end else begin
        sent_check[15:8] = b;
      end
      frame_pos = frame_pos + 6'd1;
    end
  endtask

  task automatic predict_beat(input logic req, input logic [7:0] b, input logic last,
                              input logic [3:0] idx);
    decoded_result_t r;
    logic ok;
    if (req == REQ_READ) begin
      r.kind  = KIND_READ;
      r.ok    = 1'b0;
      r.errs  = rejects;
      r.value = (idx < CHANNELS) ? servo_words[idx] : 16'd0;
      due_results.push_back(r);
    end else begin
      absorb_frame_byte(b);
      if (last) begin
        ok = (frame_pos >= FRAME_LEN) && header_ok && (sum_left == sent_check);
        if (ok) begin
          for (int i = 0; i < CHANNELS; i++)
            servo_words[i] = pending_words[i];
        end else begin
          rejects = rejects + 32'd1;
        end
        r.kind  = KIND_STATUS;
        r.ok    = ok;
        r.errs  = rejects;
        r.value = 16'd0;
        due_results.push_back(r);
        clear_frame();
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    $display("%0t checker: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
    fail_count++;
  endtask

  task automatic settle_result();
    decoded_result_t e;
    if (due_results.size() == 0) begin
      $display("%0t checker: unexpected out beat, expected none, actual %0h/%0h",
               $time, out_tuser, out_tdata[48:0]);
      fail_count++;
    end else begin
      e = due_results.pop_front();
      if (out_tuser !== e.kind)
        report("result_kind", 32'(e.kind), 32'(out_tuser));
      if (out_tdata[0] !== e.ok)
        report("frame_ok", 32'(e.ok), 32'(out_tdata[0]));
      if (out_tdata[32:1] !== e.errs)
        report("error_count", e.errs, out_tdata[32:1]);
      if (out_tdata[48:33] !== e.value)
        report("channel_value", 32'(e.value), 32'(out_tdata[48:33]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      servo_cmd = CMD_RESET;
      clear_frame();
      for (int i = 0; i < CHANNELS; i++) begin
        pending_words[i] = '0;
        servo_words[i]   = CENTER_VALUE;
      end
      rejects    = '0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        servo_cmd = cfg_data;
      if (in_tvalid && in_tready)
        predict_beat(in_tuser, in_tdata[7:0], in_tlast, in_tdata[11:8]);
      if (out_tvalid && out_tready)
        settle_result();
    end
    pending = due_results.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives the rc servo frame decoder with good, damaged, short, padded and
// noise buffers interleaved with channel reads, over several servo_command
// settings, with random gaps on in_ and random stalls on out_; checking is
// done by frame_decode_checker
// ----------------------------------------------------------------------------
module tb;
  import rcsd_pkg::*;

  typedef enum int {
    BUF_GOOD,
    BUF_PATTERN,
    BUF_BAD_LEN,
    BUF_BAD_CMD,
    BUF_BAD_SUM,
    BUF_SHORT,
    BUF_NOISE
  } buffer_kind_e;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  int          fail_count;
  int          pending;
  int          sent       = 0;
  int          sink_hold  = 0;
  logic        calm       = 1'b0;
  logic [7:0]  cur_cmd    = CMD_RESET;
  logic [7:0]  frame_bytes[$];

  rc_servo_frame_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  frame_decode_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1000, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold  <= sink_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 30)
        sink_hold <= rand_gap();
    end
  end

  task automatic send_beat(input logic req, input logic [7:0] b, input logic last,
                           input logic [3:0] idx);
    int gap;
    gap = calm ? 0 : rand_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'h0, idx, b};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_read(input logic [3:0] idx);
    send_beat(REQ_READ, 8'($urandom), 1'($urandom), idx);
  endtask

  task automatic build_frame(input logic [7:0] len_b, input logic [7:0] cmd_b,
                             input logic pattern);
    logic [15:0] w;
    logic [15:0] sum;
    frame_bytes.delete();
    frame_bytes.push_back(len_b);
    frame_bytes.push_back(cmd_b);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      w = pattern ? {{8{ch[1]}}, {8{ch[0]}}} : pick_word();
      frame_bytes.push_back(w[7:0]);
      frame_bytes.push_back(w[15:8]);
    end
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 2; i++)
      sum = sum + 16'(frame_bytes[i]);
    sum = SUM_INIT - sum;
    frame_bytes.push_back(sum[7:0]);
    frame_bytes.push_back(sum[15:8]);
  endtask

  task automatic run_buffer(input buffer_kind_e kind, input int extra, input int read_pct);
    logic [7:0] v;
    int n;
    int last_i;
    case (kind)
      BUF_PATTERN: build_frame(8'(FRAME_LEN), cur_cmd, 1'b1);
      BUF_BAD_LEN: begin
        do v = 8'($urandom); while (v == 8'(FRAME_LEN));
        build_frame(v, cur_cmd, 1'b0);
      end
      BUF_BAD_CMD: begin
        do v = 8'($urandom); while (v == cur_cmd);
        build_frame(8'(FRAME_LEN), v, 1'b0);
      end
      BUF_BAD_SUM: begin
        build_frame(8'(FRAME_LEN), cur_cmd, 1'b0);
        n = $urandom_range(2, FRAME_LEN - 1);
        frame_bytes[n] = frame_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
      end
      BUF_SHORT: begin
        build_frame(8'(FRAME_LEN), cur_cmd, 1'b0);
        n = $urandom_range(1, FRAME_LEN - 1);
        while (frame_bytes.size() > n)
          void'(frame_bytes.pop_back());
      end
      BUF_NOISE: begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
      end
      default: build_frame(8'(FRAME_LEN), cur_cmd, 1'b0);
    endcase
    repeat (extra) frame_bytes.push_back(8'($urandom));
    last_i = frame_bytes.size() - 1;
    for (int i = 0; i <= last_i; i++) begin
      if ($urandom_range(0, 99) < read_pct)
        send_read(4'($urandom));
      send_beat(REQ_FRAME, frame_bytes[i], i == last_i, 4'($urandom));
    end
  endtask

  task automatic wait_idle();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 20000);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cmd(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_cmd = v;
  endtask

  task automatic random_buffer();
    int r;
    calm = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 99) < 15)
      repeat ($urandom_range(1, 4)) send_read(4'($urandom));
    r = $urandom_range(0, 99);
    if (r < 60)
      run_buffer(BUF_GOOD, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 0, 5);
    else if (r < 67)
      run_buffer(BUF_BAD_LEN, 0, 5);
    else if (r < 74)
      run_buffer(BUF_BAD_CMD, 0, 5);
    else if (r < 82)
      run_buffer(BUF_BAD_SUM, 0, 5);
    else if (r < 91)
      run_buffer(BUF_SHORT, 0, 5);
    else
      run_buffer(BUF_NOISE, 0, 5);
  endtask

  initial begin
    logic [7:0] phase_cmd[5];
    int target;
    phase_cmd = '{8'h00, 8'hFF, 8'($urandom), CMD_RESET, 8'($urandom)};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, out-of-range indexes, then one of each buffer kind
    send_read(4'd0);
    send_read(4'd13);
    send_read(4'd14);
    send_read(4'd15);
    run_buffer(BUF_PATTERN, 0, 0);
    send_read(4'd0);
    send_read(4'd1);
    send_read(4'd2);
    send_read(4'd3);
    run_buffer(BUF_SHORT, 0, 0);
    run_buffer(BUF_BAD_LEN, 0, 0);
    run_buffer(BUF_BAD_CMD, 0, 0);
    run_buffer(BUF_BAD_SUM, 0, 0);
    run_buffer(BUF_GOOD, 3, 20);
    run_buffer(BUF_NOISE, 0, 0);

    target = sent;
    foreach (phase_cmd[p]) begin
      wait_idle();
      write_cmd(phase_cmd[p]);
      target = target + 180;
      while (sent < target)
        random_buffer();
    end

    calm = 1'b0;
    wait_idle();
    if (pending != 0)
      $display("%0t tb: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
